[rtl/s2d_pkg.sv]
// Shared constants and controller/datapath interface types for the decimal printer.
package s2d_pkg;

    localparam int MAG_W  = 32;
    localparam int DIGITS = 10;
    localparam int BCD_W  = 4 * DIGITS;
    localparam int IDX_W  = 4;
    localparam int CNT_W  = 5;
    localparam int CHAR_W = 8;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;

    typedef struct packed {
        logic load;
        logic shift;
        logic set_idx;
        logic emit_sign;
        logic emit_digit;
    } cmd_t;

    typedef struct packed {
        logic neg;
        logic idx_zero;
        logic out_free;
    } status_t;

endpackage

[rtl/s2d_dpath.sv]
// Datapath: magnitude and BCD shift registers, digit pointer and output register.
module s2d_dpath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  s2d_pkg::cmd_t                 cmd,
    output s2d_pkg::status_t              status,
    input  logic [s2d_pkg::MAG_W-1:0]     value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [s2d_pkg::CHAR_W-1:0]    out_char,
    output logic                          out_last
);

    logic [s2d_pkg::MAG_W-1:0]  mag_reg, mag_next;
    logic [s2d_pkg::BCD_W-1:0]  bcd_reg, bcd_next;
    logic [s2d_pkg::BCD_W-1:0]  bcd_adj;
    logic                       neg_reg, neg_next;
    logic [s2d_pkg::IDX_W-1:0]  idx_reg, idx_next;
    logic [s2d_pkg::IDX_W-1:0]  lead;
    logic                       valid_reg, valid_next;
    logic [s2d_pkg::CHAR_W-1:0] char_reg, char_next;
    logic                       last_reg, last_next;
    logic [3:0]                 digit;

    // Add three to every digit of five or more before the shift.
    always_comb
    begin
        for (int k = 0; k < s2d_pkg::DIGITS; k++)
        begin
            if (bcd_reg[4*k +: 4] >= 4'd5)
            begin
                bcd_adj[4*k +: 4] = bcd_reg[4*k +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[4*k +: 4] = bcd_reg[4*k +: 4];
            end
        end
    end

    // Highest nonzero digit; zero prints as a single digit.
    always_comb
    begin
        lead = '0;
        for (int k = 0; k < s2d_pkg::DIGITS; k++)
        begin
            if (bcd_reg[4*k +: 4] != 4'd0)
            begin
                lead = s2d_pkg::IDX_W'(k);
            end
        end
    end

    assign digit = bcd_reg[4*idx_reg +: 4];

    always_comb
    begin
        mag_next   = mag_reg;
        bcd_next   = bcd_reg;
        neg_next   = neg_reg;
        idx_next   = idx_reg;
        valid_next = valid_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        if (valid_reg && out_ready)
        begin
            valid_next = 1'b0;
        end
        if (cmd.load)
        begin
            neg_next = value[s2d_pkg::MAG_W-1];
            mag_next = value[s2d_pkg::MAG_W-1] ? (s2d_pkg::MAG_W'(0) - value) : value;
            bcd_next = '0;
        end
        if (cmd.shift)
        begin
            {bcd_next, mag_next} = {bcd_adj[s2d_pkg::BCD_W-2:0], mag_reg, 1'b0};
        end
        if (cmd.set_idx)
        begin
            idx_next = lead;
        end
        if (cmd.emit_sign)
        begin
            valid_next = 1'b1;
            char_next  = s2d_pkg::ASCII_MINUS;
            last_next  = 1'b0;
        end
        if (cmd.emit_digit)
        begin
            valid_next = 1'b1;
            char_next  = s2d_pkg::ASCII_ZERO + {4'd0, digit};
            last_next  = (idx_reg == '0);
            if (idx_reg != '0)
            begin
                idx_next = idx_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        bcd_reg  <= bcd_next;
        neg_reg  <= neg_next;
        idx_reg  <= idx_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign status.neg      = neg_reg;
    assign status.idx_zero = (idx_reg == '0);
    assign status.out_free = !valid_reg || out_ready;

    assign out_valid = valid_reg;
    assign out_char  = char_reg;
    assign out_last  = last_reg;

endmodule

[rtl/s2d_ctrl.sv]
// Controller: sequences conversion, sign and digit emission for one number.
module s2d_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  s2d_pkg::status_t  status,
    output s2d_pkg::cmd_t     cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CONV = 3'd1;
    localparam logic [2:0] ST_LEAD = 3'd2;
    localparam logic [2:0] ST_SIGN = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    localparam logic [s2d_pkg::CNT_W-1:0] CONV_LAST = s2d_pkg::CNT_W'(s2d_pkg::MAG_W - 1);

    logic [2:0]                state_reg, state_next;
    logic [s2d_pkg::CNT_W-1:0] cnt_reg, cnt_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cmd.shift = 1'b1;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CONV_LAST)
                begin
                    state_next = ST_LEAD;
                end
            end
            ST_LEAD:
            begin
                cmd.set_idx = 1'b1;
                state_next  = status.neg ? ST_SIGN : ST_EMIT;
            end
            ST_SIGN:
            begin
                if (status.out_free)
                begin
                    cmd.emit_sign = 1'b1;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_digit = 1'b1;
                    if (status.idx_zero)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_CONV && cnt_reg == '0))
        else $error("accepted transaction did not start conversion");

    a_conv_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CONV && cnt_reg != CONV_LAST) |=> (state_reg == ST_CONV))
        else $error("conversion left before all bits were shifted");

    a_sign_neg: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_sign |-> status.neg)
        else $error("minus sign emitted for a non-negative number");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_digit && status.idx_zero) |=> (state_reg == ST_IDLE))
        else $error("controller kept emitting after the final digit");

endmodule

[rtl/signed_int_to_decimal_ascii.sv]
// Flow: an accepted number is loaded, run through the 32-step shift-add-3 loop over its
// magnitude, which takes most of its time, and its leading digit is found; then the sign and
// digits go out one byte at a time, 1 to 11 bytes, each waiting for a free output register.
// The final byte sits in the output register while the next number is accepted.
// Reset (rst_n, asynchronous, active low) returns the controller to idle and empties the output.
module signed_int_to_decimal_ascii (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [s2d_pkg::MAG_W-1:0]     s_axis_tdata,  // [31:0] value
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [s2d_pkg::CHAR_W-1:0]    m_axis_tdata,  // [7:0] char_out
    output logic                          m_axis_tlast   // last byte of the number
);

    // The controller owns sequencing; the datapath holds the magnitude, the
    // BCD digits built by double dabble, the digit pointer and the output
    // register. Only command and status structs pass between them.
    s2d_pkg::cmd_t    cmd;
    s2d_pkg::status_t status;

    s2d_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Each transaction on the output carries one ASCII byte; the sign comes
    // first for negative numbers, then digits from the highest nonzero one.
    s2d_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .value     (s_axis_tdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_char  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule
